[hw/rtl/ufpc_pkg.sv]
// Shared types and constants for the union-find path compression unit.
package ufpc_pkg;

    localparam int NODES_DEF = 1024;
    localparam int CMD_W     = 2;
    localparam int NODE_W    = 10;
    localparam int ROOT_W    = 10;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 16;

    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MERGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic start;
        logic sel_b;
        logic walk_step;
        logic comp_step;
        logic save_ra;
        logic link;
        logic clr_step;
        logic load_out;
        logic out_zero;
    } ufpc_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic hit;
        logic comp_done;
        logic clr_last;
        logic out_free;
    } ufpc_sts_t;

endpackage

[hw/rtl/union_find_path_compression_unit.sv]
// Top level of the union-find path compression unit.
//
//  Channel  Direction  Beat contents (lowest bit first)
//  s_*      in         cmd[1:0], node_a[11:2], node_b[21:12], zero fill [23:22]
//  m_*      out        root[9:0], zero fill [15:10]
//
// A find walks from node_a to its root and then rewrites the path on a second
// pass, both paced by the single read port of the parent table. A merge adds a
// second walk and rewrite pass for node_b and then a link step.
// A clear, and the reset, sweep the table at one entry per cycle; no beat is
// taken meanwhile.
// A finished result waits in the output register while the next beat is taken;
// the unit stalls only at the end of that beat's work if the result is still held.
module union_find_path_compression_unit #(
    parameter int NODES = ufpc_pkg::NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ufpc_pkg::IN_W-1:0]    s_tdata,   // cmd, node_a, node_b
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ufpc_pkg::OUT_W-1:0]   m_tdata    // root
);

    ufpc_pkg::ufpc_cmd_t cmd;
    ufpc_pkg::ufpc_sts_t sts;

    logic [ufpc_pkg::ROOT_W-1:0] root;

    // The controller sequences each find and merge: walk to the root, rewrite the
    // path, repeat for node_b on a merge, then link and present the result.
    ufpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tdata[1:0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the parent table and the registers of the walk.
    ufpc_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_node_a (s_tdata[11:2]),
        .in_node_b (s_tdata[21:12]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_root  (root)
    );

    assign m_tdata = {{(ufpc_pkg::OUT_W - ufpc_pkg::ROOT_W){1'b0}}, root};

endmodule

[hw/rtl/ufpc_dp.sv]
// Datapath: parent table memory, chain walk registers and output register.
module ufpc_dp #(
    parameter int NODES = ufpc_pkg::NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ufpc_pkg::ufpc_cmd_t           cmd,
    output ufpc_pkg::ufpc_sts_t           sts,
    input  logic [ufpc_pkg::NODE_W-1:0]   in_node_a,
    input  logic [ufpc_pkg::NODE_W-1:0]   in_node_b,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ufpc_pkg::ROOT_W-1:0]   out_root
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    // Index beyond the table saturates to the last entry.
    function automatic logic [IDX_W-1:0] clamp_node(input logic [ufpc_pkg::NODE_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide >= 32'(NODES))
            return LAST_IDX;
        return IDX_W'(v);
    endfunction

    logic [IDX_W-1:0] mem [NODES];

    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] root_reg;
    logic [IDX_W-1:0] ra_reg;
    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ufpc_pkg::ROOT_W-1:0] out_root_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic [IDX_W-1:0] start_node;

    assign start_node = cmd.sel_b ? b_reg : a_reg;

    assign sts.hit       = (rd_data_reg == cur_reg);
    assign sts.comp_done = (cur_reg == root_reg);
    assign sts.clr_last  = (clr_cnt_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = start_node;
        if (cmd.start)
        begin
            rd_en = 1'b1;
        end
        else if ((cmd.walk_step && !sts.hit) || (cmd.comp_step && !sts.comp_done))
        begin
            rd_en   = 1'b1;
            rd_addr = rd_data_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = root_reg;
        if (cmd.comp_step && !sts.comp_done)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.link)
        begin
            wr_en   = 1'b1;
            wr_addr = root_reg;
            wr_data = ra_reg;
        end
        else if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = clr_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= clamp_node(in_node_a);
            b_reg <= clamp_node(in_node_b);
        end
        if (cmd.start)
            cur_reg <= start_node;
        else if ((cmd.walk_step && !sts.hit) || (cmd.comp_step && !sts.comp_done))
            cur_reg <= rd_data_reg;
        if (cmd.walk_step && sts.hit)
            root_reg <= cur_reg;
        if (cmd.save_ra)
            ra_reg <= root_reg;
        if (cmd.load_out)
            out_root_reg <= cmd.out_zero ? '0 : ufpc_pkg::ROOT_W'(ra_reg);
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_step)
            clr_cnt_next = sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_root  = out_root_reg;

endmodule

[hw/rtl/ufpc_ctrl.sv]
// Controller state machine sequencing walks, compression, links and clears.
module ufpc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ufpc_pkg::CMD_W-1:0]   in_cmd,
    input  ufpc_pkg::ufpc_sts_t          sts,
    output ufpc_pkg::ufpc_cmd_t          cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WSTART = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_CSTART = 4'd4;
    localparam logic [3:0] S_COMP   = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_CLR    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       merge_reg;
    logic       merge_next;
    logic       second_reg;
    logic       second_next;
    logic       zero_reg;
    logic       zero_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        merge_next  = merge_reg;
        second_next = second_reg;
        zero_next   = zero_reg;
        cmd         = '0;
        cmd.sel_b   = second_reg;
        cmd.out_zero = zero_reg;

        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    second_next = 1'b0;
                    merge_next  = (in_cmd == ufpc_pkg::CMD_MERGE);
                    zero_next   = 1'b1;
                    unique case (in_cmd) inside
                        ufpc_pkg::CMD_FIND, ufpc_pkg::CMD_MERGE:
                        begin
                            zero_next  = 1'b0;
                            state_next = S_WSTART;
                        end
                        ufpc_pkg::CMD_CLEAR:
                            state_next = S_CLR;
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_WSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.hit)
                    state_next = S_CSTART;
            end
            S_CSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                cmd.comp_step = 1'b1;
                if (sts.comp_done)
                begin
                    if (second_reg)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        cmd.save_ra = 1'b1;
                        if (merge_reg)
                        begin
                            second_next = 1'b1;
                            state_next  = S_WSTART;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_OUT;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            merge_reg  <= 1'b0;
            second_reg <= 1'b0;
            zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            merge_reg  <= merge_next;
            second_reg <= second_next;
            zero_reg   <= zero_next;
        end
    end

endmodule

[tb/tb_union_find_path_compression_unit.sv]
// Self-checking testbench for the union-find path compression unit.
`timescale 1ns / 100ps

module tb_union_find_path_compression_unit;

    typedef logic [ufpc_pkg::NODE_W-1:0] node_t;

    // The package names three commands; the fourth code is unused and must answer zero.
    localparam logic [ufpc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TB_NODES = ufpc_pkg::NODES_DEF;
    localparam int IDLE_PERCENT = 29;
    localparam int OWED_DEPTH = 16;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [ufpc_pkg::IN_W-1:0]   s_tdata  = '0;   // cmd, node_a, node_b, zero fill
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [ufpc_pkg::OUT_W-1:0]  m_tdata;         // root, zero fill

    // Our own copy of the parent pointers, kept in step with every accepted beat.
    node_t parent_mirror [TB_NODES];

    // Roots still owed by the unit, oldest first, in a small ring; each count
    // is advanced by one process only.
    node_t owed_roots [OWED_DEPTH];
    int    owed_pushed = 0;
    int    owed_popped = 0;

    int mismatch_count = 0;
    bit no_idle = 1'b0;

    union_find_path_compression_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // A hard ceiling on the run, far beyond the slowest correct run including
    // every table sweep that a clear causes.
    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // The sink side backs off at random, except during the steady stretch.
    always @(posedge clk)
    begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void reset_mirror();
        for (int i = 0; i < TB_NODES; i++)
            parent_mirror[i] = node_t'(i);
    endfunction

    // Walk up to the root, then point every node on the way straight at it.
    function automatic node_t find_and_compress(input node_t start);
        node_t top;
        node_t cur;
        node_t next;
        int    steps;
        top = start;
        steps = 0;
        while (parent_mirror[top] != top && steps < TB_NODES)
        begin
            top = parent_mirror[top];
            steps++;
        end
        cur = start;
        steps = 0;
        while (cur != top && steps < TB_NODES)
        begin
            next = parent_mirror[cur];
            parent_mirror[cur] = top;
            cur = next;
            steps++;
        end
        return top;
    endfunction

    // Applies one command to the mirror and gives the root the unit should answer.
    function automatic node_t apply_command(input logic [ufpc_pkg::CMD_W-1:0] cmd,
                                            input node_t raw_a, input node_t raw_b);
        node_t a;
        node_t b;
        node_t root_a;
        node_t root_b;
        // Indices past the table saturate; with the full table this never bites.
        a = (int'(raw_a) >= TB_NODES) ? node_t'(TB_NODES - 1) : raw_a;
        b = (int'(raw_b) >= TB_NODES) ? node_t'(TB_NODES - 1) : raw_b;
        case (cmd)
            ufpc_pkg::CMD_FIND:
                return find_and_compress(a);
            ufpc_pkg::CMD_MERGE:
            begin
                root_a = find_and_compress(a);
                root_b = find_and_compress(b);
                parent_mirror[root_b] = root_a;
                return root_a;
            end
            ufpc_pkg::CMD_CLEAR:
            begin
                reset_mirror();
                return '0;
            end
            default:
                return '0;
        endcase
    endfunction

    // Presents one beat, holds it until taken, then records what it should produce.
    // Valid stays high into the next call, so back-to-back beats need no gap.
    task automatic issue_command(input logic [ufpc_pkg::CMD_W-1:0] cmd,
                                 input node_t a, input node_t b);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        owed_roots[4'(owed_pushed)] = apply_command(cmd, a, b);
        owed_pushed++;
    endtask

    // Every result beat is held against the oldest root still owed.
    always @(posedge clk)
    begin : result_check
        node_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_pushed == owed_popped)
                report_mismatch("result with nothing owed", int'(m_tdata), -1);
            else
            begin
                want = owed_roots[4'(owed_popped)];
                owed_popped++;
                if (m_tdata[ufpc_pkg::ROOT_W-1:0] !== want)
                    report_mismatch("root", int'(m_tdata[ufpc_pkg::ROOT_W-1:0]), int'(want));
                if (m_tdata[ufpc_pkg::OUT_W-1:ufpc_pkg::ROOT_W] !== '0)
                    report_mismatch("zero fill",
                                    int'(m_tdata[ufpc_pkg::OUT_W-1:ufpc_pkg::ROOT_W]), 0);
            end
        end
    end

    // The lowest and highest indices, and an alternating bit pattern, on a fresh table.
    task automatic test_find_extremes();
        issue_command(ufpc_pkg::CMD_FIND, 10'd0, 10'd1023);
        issue_command(ufpc_pkg::CMD_FIND, 10'd1023, 10'd0);
        issue_command(ufpc_pkg::CMD_FIND, 10'h2AA, 10'h155);
    endtask

    // Merges across the extremes, a merge inside one set, and a node merged with itself.
    task automatic test_merge_cases();
        issue_command(ufpc_pkg::CMD_MERGE, 10'd0, 10'd1023);
        issue_command(ufpc_pkg::CMD_FIND, 10'd1023, 10'd0);
        issue_command(ufpc_pkg::CMD_MERGE, 10'd1023, 10'd0);
        issue_command(ufpc_pkg::CMD_MERGE, 10'd5, 10'd5);
        issue_command(ufpc_pkg::CMD_MERGE, 10'd1023, 10'd5);
    endtask

    // Builds a chain one hop at a time, then finds its far end twice: the first
    // find walks the whole chain, the second should see it already flattened.
    task automatic test_deep_chain();
        for (int i = 100; i < 108; i++)
            issue_command(ufpc_pkg::CMD_MERGE, node_t'(i + 1), node_t'(i));
        issue_command(ufpc_pkg::CMD_FIND, 10'd100, 10'd0);
        issue_command(ufpc_pkg::CMD_FIND, 10'd100, 10'd0);
    endtask

    // The unused code must leave the table alone; a clear must undo every link.
    task automatic test_unused_and_clear();
        issue_command(CMD_UNUSED, 10'd1023, 10'd1023);
        issue_command(ufpc_pkg::CMD_CLEAR, 10'd1023, 10'd0);
        issue_command(ufpc_pkg::CMD_FIND, 10'd1023, 10'd0);
        issue_command(ufpc_pkg::CMD_FIND, 10'd5, 10'd0);
    endtask

    // Mostly merges and finds within a small moving window of nodes, so that sets
    // grow, chains get deep and compression has real work; the rest is full-range
    // noise, clears and the unused command.
    task automatic test_random_mix();
        int    sent;
        int    window_base;
        int    window_span;
        int    chain_len;
        int    pick;
        node_t a;
        node_t b;
        sent = 0;
        window_base = $urandom_range(1023);
        window_span = 16;
        while (sent < 1200)
        begin
            no_idle = (sent >= 450 && sent < 750);
            if (sent % 150 == 0)
            begin
                window_base = $urandom_range(1023);
                window_span = $urandom_range(4, 64);
            end
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // A run of hop-by-hop links followed by a find from the bottom.
                chain_len = $urandom_range(4, 24);
                for (int k = 0; k < chain_len; k++)
                    issue_command(ufpc_pkg::CMD_MERGE, node_t'(window_base + k + 1),
                                  node_t'(window_base + k));
                issue_command(ufpc_pkg::CMD_FIND, node_t'(window_base),
                              node_t'($urandom_range(1023)));
                sent += chain_len + 1;
            end
            else if (pick < 6)
            begin
                issue_command(ufpc_pkg::CMD_CLEAR, node_t'($urandom_range(1023)),
                              node_t'($urandom_range(1023)));
                sent++;
            end
            else if (pick < 9)
            begin
                issue_command(CMD_UNUSED, node_t'($urandom_range(1023)),
                              node_t'($urandom_range(1023)));
                sent++;
            end
            else
            begin
                if ($urandom_range(99) < 80)
                begin
                    a = node_t'(window_base + $urandom_range(window_span - 1));
                    b = node_t'(window_base + $urandom_range(window_span - 1));
                end
                else
                begin
                    a = node_t'($urandom_range(1023));
                    b = node_t'($urandom_range(1023));
                end
                issue_command($urandom_range(1) ? ufpc_pkg::CMD_MERGE : ufpc_pkg::CMD_FIND,
                              a, b);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_mirror();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The unit sweeps its table after reset; the first beat simply waits for ready.
        test_find_extremes();
        test_merge_cases();
        test_deep_chain();
        test_unused_and_clear();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (owed_pushed != owed_popped)
            @(posedge clk);
        // A short tail catches any stray result beat.
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
